FILE: hw/rtl/gfc_pkg.sv
`default_nettype none
package gfc_pkg;
  typedef logic [16:0] finger_t;
  typedef logic [9:0] count_t;
  typedef logic [25:0] force_t;
  typedef logic [11:0] gain_t;
  typedef logic [19:0] level_t;
  typedef logic signed [55:0] denom_t;

  typedef enum logic [1:0] {
    REG_GAIN      = 2'd0,
    REG_MIN_POS   = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_DEADBAND  = 2'd3
  } cfg_idx_t;

  localparam logic [27:0] RECIP_1000 = 28'd137438953;  // floor(2^37 / 1000)
  localparam logic [59:0] FORCE_NUM  = 60'd314572800000000000;
  localparam logic [21:0] STEP_MULT  = 22'd3221832;
  localparam int QUO_BITS = 26;
  localparam int DEN_LAT  = 5;
  localparam int DIV_LAT  = QUO_BITS + 1;
  localparam int FRONT_LAT = DEN_LAT + DIV_LAT;
endpackage
`default_nettype wire

FILE: hw/rtl/gfc_denom.sv
`default_nettype none
module gfc_denom (
  input  wire               clk,
  input  gfc_pkg::finger_t  finger,
  input  gfc_pkg::count_t   count,
  output gfc_pkg::denom_t   denom
);
  import gfc_pkg::*;

  logic [9:0] k;
  logic signed [30:0] s_nm;
  logic [30:0] s_mag;
  logic sgn1_r, sgn2_r;
  logic [27:0] x1_r, x2_r;
  logic [55:0] prod2;
  logic [17:0] q0_r;
  logic [28:0] rem3;
  logic [17:0] q3;
  logic [17:0] q3_r;
  logic signed [18:0] s3_r, s4_r;
  logic [35:0] sq4_r;
  logic signed [55:0] lin4_r;
  logic signed [55:0] cube5;
  denom_t denom_r;

  assign k = 10'd1023 - count;
  assign s_nm = $signed(31'd60250000 - 31'(k) * 31'd65092 - 31'(finger) * 31'd1000);
  assign s_mag = s_nm[30] ? 31'(-s_nm) : 31'(s_nm);
  assign prod2 = 56'(x1_r) * 56'(RECIP_1000);
  // estimate is exact or one low; fix with a single compare
  assign rem3 = 29'(x2_r) - 29'(q0_r) * 29'd1000;
  assign q3 = q0_r + ((rem3 >= 29'd1000) ? 18'd1 : 18'd0);
  assign cube5 = 56'($signed({1'b0, sq4_r})) * 56'(s4_r);

  always_ff @(posedge clk) begin
    sgn1_r  <= s_nm[30];
    x1_r    <= 28'(s_mag) + 28'd500;
    sgn2_r  <= sgn1_r;
    x2_r    <= x1_r;
    q0_r    <= 18'(prod2 >> 37);
    q3_r    <= q3;
    s3_r    <= sgn2_r ? -$signed({1'b0, q3}) : $signed({1'b0, q3});
    sq4_r   <= 36'(q3_r) * 36'(q3_r);
    s4_r    <= s3_r;
    lin4_r  <= 56'(s3_r) * 56'sd53000000 + 56'sd230000000000;
    denom_r <= cube5 + lin4_r;
  end

  assign denom = denom_r;
endmodule
`default_nettype wire

FILE: hw/rtl/gfc_div.sv
`default_nettype none
module gfc_div (
  input  wire              clk,
  input  gfc_pkg::denom_t  denom,
  output gfc_pkg::force_t  force_q
);
  import gfc_pkg::*;

  logic [47:0] rem_r [QUO_BITS+1];
  logic [47:0] dvs_r [QUO_BITS+1];
  logic [QUO_BITS-1:0] lo_r [QUO_BITS+1];
  logic [QUO_BITS-1:0] quo_r [QUO_BITS+1];
  logic sat_r [QUO_BITS+1];

  logic [47:0] dvs0;
  logic [59:0] num0;
  logic dpos;

  assign dpos = (denom > 56'sd0);
  assign dvs0 = denom[47:0];
  assign num0 = FORCE_NUM + 60'(dvs0 >> 1);

  // setup: flag saturation, seed remainder with the upper numerator bits
  always_ff @(posedge clk) begin
    sat_r[0] <= !dpos || (48'(num0[59:QUO_BITS]) >= dvs0);
    rem_r[0] <= 48'(num0[59:QUO_BITS]);
    dvs_r[0] <= dvs0;
    lo_r[0]  <= num0[QUO_BITS-1:0];
    quo_r[0] <= '0;
  end

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_step
    logic [48:0] trial;
    logic take;
    assign trial = {rem_r[i], lo_r[i][QUO_BITS-1]};
    assign take = trial >= 49'(dvs_r[i]);
    always_ff @(posedge clk) begin
      rem_r[i+1] <= take ? 48'(trial - 49'(dvs_r[i])) : 48'(trial);
      dvs_r[i+1] <= dvs_r[i];
      lo_r[i+1]  <= lo_r[i] << 1;
      quo_r[i+1] <= {quo_r[i][QUO_BITS-2:0], take};
      sat_r[i+1] <= sat_r[i];
    end
  end

  assign force_q = sat_r[QUO_BITS] ? '1 : quo_r[QUO_BITS];
endmodule
`default_nettype wire

FILE: hw/rtl/gfc_goal.sv
`default_nettype none
module gfc_goal (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               valid,
  input  gfc_pkg::count_t   count,
  input  gfc_pkg::force_t   force_a,
  input  gfc_pkg::force_t   force_b,
  input  gfc_pkg::gain_t    gain,
  input  gfc_pkg::count_t   min_position,
  input  gfc_pkg::level_t   threshold,
  input  gfc_pkg::level_t   deadband,
  output logic              out_valid,
  output gfc_pkg::count_t   goal,
  output gfc_pkg::force_t   net_force
);
  import gfc_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  count_t c1_r, c2_r, c3_r, c4_r;
  force_t n1_r, n2_r, n3_r, n4_r;
  logic signed [27:0] e1_r;
  logic [26:0] mag2_r;
  logic neg2_r, neg3_r, neg4_r, pass2_r;
  logic [38:0] p3_r;
  logic [60:0] p4_r;
  force_t net1;
  logic [26:0] mag1;
  logic [61:0] base, vmag;
  logic vneg;
  logic [21:0] gmag;
  logic signed [23:0] gval;
  count_t gclamp;
  count_t goal_r;
  force_t net_r;
  logic ov_r;

  assign net1 = (force_a > force_b) ? force_a - force_b : force_b - force_a;
  assign mag1 = e1_r[27] ? 27'(-e1_r) : 27'(e1_r);

  assign base = 62'(c4_r) << 40;
  always_comb begin
    vneg = 1'b0;
    if (!neg4_r) begin
      vmag = base + 62'(p4_r);
    end else if (62'(p4_r) <= base) begin
      vmag = base - 62'(p4_r);
    end else begin
      vmag = 62'(p4_r) - base;
      vneg = 1'b1;
    end
    gmag = 22'((vmag + (62'd1 << 39)) >> 40);
    gval = vneg ? -$signed({2'b0, gmag}) : $signed({2'b0, gmag});
    if (gval > 24'sd1023) begin
      gclamp = 10'd1023;
    end else if (gval < $signed({14'b0, min_position})) begin
      gclamp = (min_position < 10'd10) ? 10'd0 : min_position - 10'd10;
    end else begin
      gclamp = 10'(gval);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r <= valid;
      v2_r <= v1_r;
      v3_r <= v2_r && pass2_r;
      v4_r <= v3_r;
      ov_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_r    <= count;
    n1_r    <= net1;
    e1_r    <= $signed({2'b0, net1}) - $signed({8'b0, threshold});
    c2_r    <= c1_r;
    n2_r    <= n1_r;
    mag2_r  <= mag1;
    neg2_r  <= e1_r[27];
    pass2_r <= mag1 > 27'(deadband);
    c3_r    <= c2_r;
    n3_r    <= n2_r;
    neg3_r  <= neg2_r;
    p3_r    <= 39'(gain) * 39'(mag2_r);
    c4_r    <= c3_r;
    n4_r    <= n3_r;
    neg4_r  <= neg3_r;
    p4_r    <= 61'(p3_r) * 61'(STEP_MULT);
    goal_r  <= gclamp;
    net_r   <= n4_r;
  end

  assign out_valid = ov_r;
  assign goal = goal_r;
  assign net_force = net_r;
endmodule
`default_nettype wire

FILE: hw/rtl/magnet_grip_force_corrector_core.sv
`default_nettype none
// Magnet grip force corrector.
// Input channel: a transaction is taken on every rising edge with start high
// and busy low. busy never rises, so a new item can enter every cycle.
// Each item carries both finger positions, the servo count and halt.
// Result channel: out_valid pulses for one cycle with out_goal_count and
// out_object_force; the receiver cannot stall and must take it then.
// From accept to out_valid: 5 stages build each finger's force
// denominator, 27 stages run the restoring divider (a setup stage, then
// one quotient bit per stage, one divider per finger), 5 stages form the
// net force, error, gain products and the rounded, clamped goal.
// Throughput: one item per cycle; the divider pipeline sets the depth.
// Items with halt set, or whose force error stays inside the deadband,
// produce no result.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (gain,
// min_position, force_threshold, deadband); write only while idle.
// Reset (synchronous, rst_n low) clears every valid bit in flight and
// loads the register defaults.
module magnet_grip_force_corrector_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  gfc_pkg::finger_t   in_finger_one_um,
  input  gfc_pkg::finger_t   in_finger_two_um,
  input  gfc_pkg::count_t    in_servo_count,
  input  wire                in_halt,
  output logic               out_valid,
  output gfc_pkg::count_t    out_goal_count,
  output gfc_pkg::force_t    out_object_force,
  input  wire                cfg_we,
  input  wire [1:0]          cfg_index,
  input  wire [19:0]         cfg_wdata
);
  import gfc_pkg::*;

  gain_t  gain_r;
  count_t min_pos_r;
  level_t thresh_r;
  level_t deadband_r;

  logic   vld_r [FRONT_LAT];
  count_t cnt_r [FRONT_LAT];

  denom_t den_a, den_b;
  force_t frc_a, frc_b;

  assign busy = 1'b0;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= 12'd200;
      min_pos_r  <= 10'd650;
      thresh_r   <= 20'd196608;
      deadband_r <= 20'd32768;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_GAIN:      gain_r     <= cfg_wdata[11:0];
        REG_MIN_POS:   min_pos_r  <= cfg_wdata[9:0];
        REG_THRESHOLD: thresh_r   <= cfg_wdata;
        REG_DEADBAND:  deadband_r <= cfg_wdata;
        default:       gain_r     <= gain_r;
      endcase
    end
  end

  // carry valid and servo count alongside the force datapath; drop halted items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRONT_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= start && !busy && !in_halt;
      for (int i = 1; i < FRONT_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r[0] <= in_servo_count;
    for (int i = 1; i < FRONT_LAT; i++) begin
      cnt_r[i] <= cnt_r[i-1];
    end
  end

  // the first denominator stage registers the inputs directly
  gfc_denom u_den_a (.clk(clk), .finger(in_finger_one_um), .count(in_servo_count),
                     .denom(den_a));
  gfc_denom u_den_b (.clk(clk), .finger(in_finger_two_um), .count(in_servo_count),
                     .denom(den_b));

  gfc_div u_div_a (.clk(clk), .denom(den_a), .force_q(frc_a));
  gfc_div u_div_b (.clk(clk), .denom(den_b), .force_q(frc_b));

  gfc_goal u_goal (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (vld_r[FRONT_LAT-1]),
    .count        (cnt_r[FRONT_LAT-1]),
    .force_a      (frc_a),
    .force_b      (frc_b),
    .gain         (gain_r),
    .min_position (min_pos_r),
    .threshold    (thresh_r),
    .deadband     (deadband_r),
    .out_valid    (out_valid),
    .goal         (out_goal_count),
    .net_force    (out_object_force)
  );
endmodule
`default_nettype wire

FILE: dv/magnet_grip_force_corrector_checker.sv
`default_nettype none
module magnet_grip_force_corrector_checker
  import gfc_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  input  wire        busy,
  input  finger_t    in_finger_one_um,
  input  finger_t    in_finger_two_um,
  input  count_t     in_servo_count,
  input  wire        in_halt,
  input  wire        out_valid,
  input  count_t     out_goal_count,
  input  force_t     out_object_force,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [19:0] cfg_wdata,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    count_t goal;
    force_t net;
  } grip_result_t;

  gain_t  gain_q;
  count_t min_pos_q;
  level_t threshold_q;
  level_t deadband_q;
  grip_result_t goal_queue[$];

  assign pending = goal_queue.size();

  function automatic longint finger_force(longint k, longint finger);
    longint s_nm, s, d, q;
    s_nm = 64'sd60250000 - 64'sd65092 * k - 64'sd1000 * finger;
    if (s_nm >= 0) s = (s_nm + 500) / 1000;
    else s = -((-s_nm + 500) / 1000);
    d = s * s * s + 64'sd53000000 * s + 64'sd230000000000;
    if (d <= 0) return 64'sd67108863;
    q = (64'sd314572800000000000 + d / 2) / d;
    if (q > 64'sd67108863) q = 64'sd67108863;
    return q;
  endfunction

  // Return 1 and fill the result when the item calls for a correction.
  function automatic bit predict_goal(input finger_t f1, input finger_t f2,
                                      input count_t cnt, output grip_result_t r);
    longint k, a, b, net, e, mag, goal;
    longint unsigned prod, base, vmag;
    bit neg;
    k = 1023 - longint'(cnt);
    a = finger_force(k, longint'(f1));
    b = finger_force(k, longint'(f2));
    net = a > b ? a - b : b - a;
    e = net - longint'(threshold_q);
    mag = e < 0 ? -e : e;
    r = '0;
    if (mag <= longint'(deadband_q)) return 0;
    prod = longint'(gain_q) * mag * 64'd3221832;
    base = longint'(cnt) << 40;
    neg = 0;
    if (e >= 0) vmag = base + prod;
    else if (prod <= base) vmag = base - prod;
    else begin
      vmag = prod - base;
      neg = 1;
    end
    goal = longint'((vmag + (64'd1 << 39)) >> 40);
    if (neg) goal = -goal;
    if (goal > 1023) goal = 1023;
    else if (goal < longint'(min_pos_q)) begin
      goal = longint'(min_pos_q) - 10;
      if (goal < 0) goal = 0;
    end
    r.goal = count_t'(goal);
    r.net = force_t'(net);
    return 1;
  endfunction

  always @(posedge clk) begin
    grip_result_t r, exp_r;
    if (!rst_n) begin
      gain_q      <= 12'd200;
      min_pos_q   <= 10'd650;
      threshold_q <= 20'd196608;
      deadband_q  <= 20'd32768;
      fail_count  <= 0;
      goal_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          REG_GAIN:      gain_q <= cfg_wdata[11:0];
          REG_MIN_POS:   min_pos_q <= cfg_wdata[9:0];
          REG_THRESHOLD: threshold_q <= cfg_wdata;
          REG_DEADBAND:  deadband_q <= cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy && !in_halt &&
          predict_goal(in_finger_one_um, in_finger_two_um, in_servo_count, r))
        goal_queue.push_back(r);
      if (out_valid) begin
        if (goal_queue.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result goal=%0d force=%0d", out_goal_count,
                     out_object_force);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = goal_queue.pop_front();
          if (exp_r.goal !== out_goal_count || exp_r.net !== out_object_force) begin
            if (fail_count < 10)
              $display("mismatch goal exp %0d got %0d, force exp %0d got %0d",
                       exp_r.goal, out_goal_count, exp_r.net, out_object_force);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: dv/magnet_grip_force_corrector_core_test.sv
`default_nettype none
module magnet_grip_force_corrector_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gfc_pkg::*;

  logic clk, rst_n, start, busy, in_halt, out_valid, cfg_we;
  finger_t in_finger_one_um, in_finger_two_um;
  count_t in_servo_count, out_goal_count;
  force_t out_object_force;
  logic [1:0] cfg_index;
  logic [19:0] cfg_wdata;
  int fail_count, pending, cycles;
  int send_idle_pct;

  magnet_grip_force_corrector_core DUT (.*);
  magnet_grip_force_corrector_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run; the slowest correct run is far below this.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Present one transaction at the falling edge, hold until taken.
  // Leave start high so the next transaction can follow with no gap.
  task automatic send_item(input finger_t f1, input finger_t f2,
                           input count_t cnt, input logic h);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    in_finger_one_um <= f1;
    in_finger_two_um <= f2;
    in_servo_count <= cnt;
    in_halt <= h;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start, drain results, then cover the latency of items that produce none.
  task automatic wait_idle();
    start <= 0;
    while (pending != 0) @(negedge clk);
    repeat (FRONT_LAT + 10) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [19:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  // Random finger position; bias toward the band where forces matter.
  function automatic finger_t rand_finger();
    case ($urandom_range(9))
      0: return finger_t'($urandom);
      1, 2: return finger_t'($urandom_range(70000));
      default: return finger_t'($urandom_range(30000, 62000));
    endcase
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++)
      send_item(rand_finger(), rand_finger(), count_t'($urandom),
                ($urandom_range(15) == 0));
  endtask

  initial begin
    rst_n = 0; start = 0; cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    in_finger_one_um = 0; in_finger_two_um = 0; in_servo_count = 0; in_halt = 0;
    send_idle_pct = 0;
    repeat (4) @(negedge clk);
    rst_n = 1;

    // Directed: field extremes, halt, saturated and near forces.
    send_item(17'd0, 17'd0, 10'd0, 0);
    send_item(17'h1FFFF, 17'd0, 10'd1023, 0);
    send_item(17'd0, 17'h1FFFF, 10'd0, 0);
    send_item(17'h1FFFF, 17'h1FFFF, 10'd512, 0);
    send_item(17'd70000, 17'd0, 10'd1023, 1);
    send_item(17'd60000, 17'd20000, 10'd1023, 0);
    send_item(17'd61000, 17'd40000, 10'd700, 0);
    send_item(17'd55000, 17'd54000, 10'd900, 0);
    send_item(17'd50000, 17'd50000, 10'd800, 0);
    send_item(17'd62000, 17'd0, 10'd1000, 0);
    send_item(17'd58000, 17'd57500, 10'd1020, 0);
    wait_idle();
    write_reg(REG_GAIN, 20'd4095);
    write_reg(REG_MIN_POS, 20'd10);
    write_reg(REG_THRESHOLD, 20'd0);
    write_reg(REG_DEADBAND, 20'd0);
    send_item(17'd60000, 17'd30000, 10'd1023, 0);
    send_item(17'd45000, 17'd44000, 10'd5, 0);
    send_item(17'd45000, 17'd45000, 10'd300, 0);
    send_item(17'd62000, 17'd1000, 10'd0, 0);
    wait_idle();
    write_reg(REG_GAIN, 20'd0);
    write_reg(REG_MIN_POS, 20'd1023);
    write_reg(REG_THRESHOLD, 20'hFFFFF);
    write_reg(REG_DEADBAND, 20'hFFFFF);
    send_item(17'd62000, 17'd0, 10'd1023, 0);
    send_item(17'd20000, 17'd10000, 10'd100, 0);
    wait_idle();

    send_idle_pct = 38;
    write_reg(REG_GAIN, 20'd200);
    write_reg(REG_MIN_POS, 20'd650);
    write_reg(REG_THRESHOLD, 20'd196608);
    write_reg(REG_DEADBAND, 20'd32768);
    random_phase(150);
    wait_idle();

    send_idle_pct = 82;
    write_reg(REG_GAIN, 20'($urandom_range(4095)));
    write_reg(REG_MIN_POS, 20'($urandom_range(10, 1023)));
    write_reg(REG_THRESHOLD, 20'($urandom_range(300000)));
    write_reg(REG_DEADBAND, 20'($urandom_range(20000)));
    random_phase(150);
    wait_idle();

    send_idle_pct = 0;
    write_reg(REG_GAIN, 20'd1);
    write_reg(REG_MIN_POS, 20'd10);
    write_reg(REG_THRESHOLD, 20'd65536);
    write_reg(REG_DEADBAND, 20'd100);
    random_phase(150);
    wait_idle();

    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
